// ----- hdl/sft_pkg.sv -----
// Shared types and constants of the size frequency tracker.
package sft_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 264;

  localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] REPLACE_LIMIT = 32'd5;
  localparam logic [31:0] MIN_CALLS_RESET = 32'd100;
  localparam logic [0:0] REG_MIN_CALLS = 1'b0;

  typedef enum logic [1:0] {
    ACT_MATCH   = 2'd0,
    ACT_FILL    = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_CALLS,
    ST_ADD_ELEM,
    ST_ADD_TIME,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_DOM_SCAN,
    ST_DOM_MUL,
    ST_DOM_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] hits;
    logic [63:0] etime;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

endpackage

// ----- hdl/size_frequency_tracker.sv -----
// Top level of the size frequency tracker: totals, table sequencer and ports.
//
// Each input beat on the s_ channel reports one execution (element count and
// time). The block updates saturating totals of calls, elements and time,
// looks the element count up in a table of TABLE_ENTRIES tracked counts and
// then scans the table for the most frequent count. One result beat leaves
// on the m_ channel for every input beat.
// The table memory has one read port and is scanned one entry a cycle, once
// for the lookup and once for the dominant count, and a single shared 64-bit
// saturating adder does the totals, the entry time and the 5x product in
// turn. s_tready is high only while the sequencer is idle.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver holds the sequencer in its final step until
// the register is free. min_calls is written over the APB port at address 0.
// Reset clears the totals and the fill count; table entries need no clearing.
module size_frequency_tracker #(
  parameter int TABLE_ENTRIES = sft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // elem_count [31:0], exec_time_ns [71:32]
  input  logic [sft_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // action [1:0], slot [4:2], slot_count [36:5], calls_total [100:37],
  // elements_total [164:101], time_total [228:165], specialize_advised [229],
  // dominant_valid [230], dominant_count_value [262:231], zero [263]
  output logic [sft_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int IW1 = $clog2(TABLE_ENTRIES + 1);

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  sft_pkg::state_t   state, state_next;
  logic [31:0]       min_calls;
  logic [63:0]       calls_sum, calls_sum_next;
  logic [63:0]       elements_sum, elements_sum_next;
  logic [63:0]       time_sum, time_sum_next;
  logic [IW1-1:0]    used_entries, used_entries_next;
  logic              m_tvalid_next;

  logic [31:0]       key_in, key_in_next;
  logic [39:0]       time_in, time_in_next;
  logic [IW1-1:0]    ra, ra_next;
  logic              chk_vld, chk_vld_next;
  logic [IW-1:0]     chk_idx, chk_idx_next;
  logic [31:0]       min_hits, min_hits_next;
  logic [IW-1:0]     min_idx, min_idx_next;
  logic [31:0]       best_hits, best_hits_next;
  logic [31:0]       best_key, best_key_next;
  logic [34:0]       five_c, five_c_next;
  logic              dom_valid, dom_valid_next;
  logic [31:0]       dom_key, dom_key_next;
  sft_pkg::action_t  action, action_next;
  logic [IW-1:0]     slot, slot_next;
  logic [31:0]       count, count_next;
  logic [sft_pkg::OUT_TDATA_W-1:0] out_data, out_data_next;

  sft_pkg::tbl_ctl_t tbl_ctl;
  logic [IW-1:0]     wr_addr;
  sft_pkg::entry_t   wr_entry;
  sft_pkg::entry_t   rd_entry;

  logic [63:0]       add_a, add_b, add_sum;
  logic              match, last, spec;
  logic [31:0]       hits_new;

  sft_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .ctl     (tbl_ctl),
    .rd_addr (ra[IW-1:0]),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_data (rd_entry)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sft_pkg::REG_MIN_CALLS) ? min_calls : 32'd0;
  assign s_tready = (state == sft_pkg::ST_IDLE);
  assign m_tdata = out_data;

  assign add_sum = sat_add(add_a, add_b);
  assign match = (rd_entry.key == key_in);
  assign last = ((IW1'(chk_idx) + IW1'(1)) == used_entries);
  assign hits_new = (rd_entry.hits == sft_pkg::HITS_MAX) ? rd_entry.hits
                                                         : rd_entry.hits + 32'd1;
  assign spec = (calls_sum >= {32'd0, min_calls});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sft_pkg::ST_IDLE;
      min_calls <= sft_pkg::MIN_CALLS_RESET;
      calls_sum <= '0;
      elements_sum <= '0;
      time_sum <= '0;
      used_entries <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      calls_sum <= calls_sum_next;
      elements_sum <= elements_sum_next;
      time_sum <= time_sum_next;
      used_entries <= used_entries_next;
      m_tvalid <= m_tvalid_next;
      if (psel && penable && pwrite && pready && paddr[2] == sft_pkg::REG_MIN_CALLS) begin
        min_calls <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_in <= key_in_next;
    time_in <= time_in_next;
    ra <= ra_next;
    chk_vld <= chk_vld_next;
    chk_idx <= chk_idx_next;
    min_hits <= min_hits_next;
    min_idx <= min_idx_next;
    best_hits <= best_hits_next;
    best_key <= best_key_next;
    five_c <= five_c_next;
    dom_valid <= dom_valid_next;
    dom_key <= dom_key_next;
    action <= action_next;
    slot <= slot_next;
    count <= count_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next = state;
    calls_sum_next = calls_sum;
    elements_sum_next = elements_sum;
    time_sum_next = time_sum;
    used_entries_next = used_entries;
    m_tvalid_next = m_tvalid && !m_tready;
    key_in_next = key_in;
    time_in_next = time_in;
    ra_next = ra;
    chk_vld_next = 1'b0;
    chk_idx_next = chk_idx;
    min_hits_next = min_hits;
    min_idx_next = min_idx;
    best_hits_next = best_hits;
    best_key_next = best_key;
    five_c_next = five_c;
    dom_valid_next = dom_valid;
    dom_key_next = dom_key;
    action_next = action;
    slot_next = slot;
    count_next = count;
    out_data_next = out_data;
    tbl_ctl = '0;
    wr_addr = slot;
    wr_entry = '{key: key_in, hits: 32'd1, etime: {24'd0, time_in}};
    add_a = '0;
    add_b = '0;

    unique case (state)
      sft_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          key_in_next = s_tdata[31:0];
          time_in_next = s_tdata[71:32];
          state_next = sft_pkg::ST_ADD_CALLS;
        end
      end
      sft_pkg::ST_ADD_CALLS: begin
        add_a = calls_sum;
        add_b = 64'd1;
        calls_sum_next = add_sum;
        state_next = sft_pkg::ST_ADD_ELEM;
      end
      sft_pkg::ST_ADD_ELEM: begin
        add_a = elements_sum;
        add_b = {32'd0, key_in};
        elements_sum_next = add_sum;
        state_next = sft_pkg::ST_ADD_TIME;
      end
      sft_pkg::ST_ADD_TIME: begin
        add_a = time_sum;
        add_b = {24'd0, time_in};
        time_sum_next = add_sum;
        ra_next = '0;
        state_next = (used_entries == '0) ? sft_pkg::ST_MISS : sft_pkg::ST_SCAN;
      end
      sft_pkg::ST_SCAN: begin
        tbl_ctl.rd_en = (ra < used_entries) && !(chk_vld && (match || last));
        if (chk_vld) begin
          if (match) begin
            slot_next = chk_idx;
            state_next = sft_pkg::ST_HIT;
          end else begin
            if (chk_idx == '0 || rd_entry.hits < min_hits) begin
              min_hits_next = rd_entry.hits;
              min_idx_next = chk_idx;
            end
            if (last) begin
              state_next = sft_pkg::ST_MISS;
            end
          end
        end
      end
      sft_pkg::ST_HIT: begin
        add_a = rd_entry.etime;
        add_b = {24'd0, time_in};
        tbl_ctl.wr_en = 1'b1;
        wr_entry = '{key: key_in, hits: hits_new, etime: add_sum};
        action_next = sft_pkg::ACT_MATCH;
        count_next = hits_new;
        ra_next = '0;
        best_hits_next = '0;
        state_next = sft_pkg::ST_DOM_SCAN;
      end
      sft_pkg::ST_MISS: begin
        if (used_entries < IW1'(TABLE_ENTRIES)) begin
          tbl_ctl.wr_en = 1'b1;
          wr_addr = used_entries[IW-1:0];
          used_entries_next = used_entries + IW1'(1);
          action_next = sft_pkg::ACT_FILL;
          slot_next = used_entries[IW-1:0];
          count_next = 32'd1;
        end else if (min_hits < sft_pkg::REPLACE_LIMIT) begin
          tbl_ctl.wr_en = 1'b1;
          wr_addr = min_idx;
          action_next = sft_pkg::ACT_REPLACE;
          slot_next = min_idx;
          count_next = 32'd1;
        end else begin
          action_next = sft_pkg::ACT_NONE;
          slot_next = '0;
          count_next = '0;
        end
        ra_next = '0;
        best_hits_next = '0;
        state_next = sft_pkg::ST_DOM_SCAN;
      end
      sft_pkg::ST_DOM_SCAN: begin
        tbl_ctl.rd_en = (ra < used_entries) && !(chk_vld && last);
        if (chk_vld) begin
          if (chk_idx == '0 || rd_entry.hits > best_hits) begin
            best_hits_next = rd_entry.hits;
            best_key_next = rd_entry.key;
          end
          if (last) begin
            state_next = sft_pkg::ST_DOM_MUL;
          end
        end else if (used_entries == '0) begin
          state_next = sft_pkg::ST_DOM_MUL;
        end
      end
      sft_pkg::ST_DOM_MUL: begin
        add_a = {30'd0, best_hits, 2'b00};
        add_b = {32'd0, best_hits};
        five_c_next = add_sum[34:0];
        state_next = sft_pkg::ST_DOM_CMP;
      end
      sft_pkg::ST_DOM_CMP: begin
        dom_valid_next = (best_hits != '0) && (calls_sum[63:62] == 2'b00) &&
                         ({29'd0, five_c} >= {calls_sum[61:0], 2'b00});
        dom_key_next = best_key;
        state_next = sft_pkg::ST_DONE;
      end
      sft_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_data_next = {1'b0, dom_valid ? dom_key : 32'd0, dom_valid, spec,
                           time_sum, elements_sum, calls_sum, count, 3'(slot),
                           action};
          m_tvalid_next = 1'b1;
          state_next = sft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sft_pkg::ST_IDLE;
      end
    endcase

    if (tbl_ctl.rd_en) begin
      ra_next = ra + IW1'(1);
      chk_vld_next = 1'b1;
      chk_idx_next = ra[IW-1:0];
    end
  end

endmodule

// ----- hdl/sft_table.sv -----
// Entry memory of the frequency table with one write and one registered read port.
module sft_table #(
  parameter int ENTRIES = sft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  sft_pkg::tbl_ctl_t          ctl,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  sft_pkg::entry_t            wr_data,
  output sft_pkg::entry_t            rd_data
);

  sft_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/sft_checker.sv -----
// Port-level assertions of the size frequency tracker and their bind.
module sft_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [sft_pkg::OUT_TDATA_W-1:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("Block is not idle after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input taken while an item is in progress.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result beat changed while stalled.");

  a_untracked_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == sft_pkg::ACT_NONE |-> m_tdata[36:2] == '0)
    else $error("Untracked result carries a slot or count.");

  a_dominant_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[100:37] != '0 && (m_tdata[230] || m_tdata[262:231] == '0))
    else $error("Result totals or dominant count inconsistent.");

endmodule

bind size_frequency_tracker sft_checker u_sft_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- sim/tb_size_frequency_tracker.sv -----
`timescale 1ns / 100ps
// Testbench of the size frequency tracker: execution reports checked against a table model.
module tb_size_frequency_tracker;

  localparam logic [2:0] MIN_CALLS_ADDR = 3'(4 * sft_pkg::REG_MIN_CALLS);
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam logic [39:0] TIME_MAX = '1;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 300;

  typedef enum {MIX_HOT, MIX_CHURN, MIX_POOL, MIX_NEAR} key_mix_t;

  typedef struct packed {
    sft_pkg::action_t action;
    logic [2:0]       slot;
    logic [31:0]      slot_count;
    logic [63:0]      calls_total;
    logic [63:0]      elements_total;
    logic [63:0]      ns_total;
    logic             specialize;
    logic             dom_valid;
    logic [31:0]      dom_key;
  } report_t;

  class freq_checker_t;
    logic [31:0] min_calls;
    logic [63:0] calls_sum;
    logic [63:0] elem_sum;
    logic [63:0] ns_sum;
    int unsigned used;
    logic [31:0] key_tab [sft_pkg::TABLE_ENTRIES_DEF];
    logic [31:0] hits_tab [sft_pkg::TABLE_ENTRIES_DEF];
    logic [63:0] ns_tab [sft_pkg::TABLE_ENTRIES_DEF];
    report_t awaited [$];
    int unsigned fails;

    function new();
      min_calls = sft_pkg::MIN_CALLS_RESET;
      calls_sum = '0;
      elem_sum = '0;
      ns_sum = '0;
      used = 0;
      fails = 0;
      foreach (key_tab[i]) begin
        key_tab[i] = '0;
        hits_tab[i] = '0;
        ns_tab[i] = '0;
      end
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function void record_call(logic [31:0] cnt, logic [39:0] t);
      report_t r;
      int low;
      int best;
      bit hit;
      logic [66:0] five_c;
      logic [66:0] four_t;
      calls_sum = sat_add(calls_sum, 64'd1);
      elem_sum = sat_add(elem_sum, {32'd0, cnt});
      ns_sum = sat_add(ns_sum, {24'd0, t});
      r = '0;
      r.action = sft_pkg::ACT_NONE;
      hit = 0;
      for (int i = 0; i < used; i++) begin
        if (!hit && key_tab[i] == cnt) begin
          if (hits_tab[i] != sft_pkg::HITS_MAX) hits_tab[i]++;
          ns_tab[i] = sat_add(ns_tab[i], {24'd0, t});
          r.action = sft_pkg::ACT_MATCH;
          r.slot = 3'(i);
          r.slot_count = hits_tab[i];
          hit = 1;
        end
      end
      if (!hit) begin
        if (used < sft_pkg::TABLE_ENTRIES_DEF) begin
          key_tab[used] = cnt;
          hits_tab[used] = 32'd1;
          ns_tab[used] = {24'd0, t};
          r.action = sft_pkg::ACT_FILL;
          r.slot = 3'(used);
          r.slot_count = 32'd1;
          used++;
        end else begin
          low = 0;
          for (int i = 1; i < sft_pkg::TABLE_ENTRIES_DEF; i++)
            if (hits_tab[i] < hits_tab[low]) low = i;
          if (hits_tab[low] < sft_pkg::REPLACE_LIMIT) begin
            key_tab[low] = cnt;
            hits_tab[low] = 32'd1;
            ns_tab[low] = {24'd0, t};
            r.action = sft_pkg::ACT_REPLACE;
            r.slot = 3'(low);
            r.slot_count = 32'd1;
          end
        end
      end
      best = 0;
      for (int i = 1; i < used; i++)
        if (hits_tab[i] > hits_tab[best]) best = i;
      r.calls_total = calls_sum;
      r.elements_total = elem_sum;
      r.ns_total = ns_sum;
      r.specialize = (calls_sum >= {32'd0, min_calls});
      five_c = 67'(hits_tab[best]) * 67'd5;
      four_t = {1'b0, calls_sum, 2'b00};
      if (used > 0 && hits_tab[best] != 0 && five_c >= four_t) begin
        r.dom_valid = 1'b1;
        r.dom_key = key_tab[best];
      end
      awaited = {awaited, r};
    endfunction

    function void check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        fails++;
      end
    endfunction

    function void check_beat(logic [sft_pkg::OUT_TDATA_W-1:0] d);
      report_t e;
      if (awaited.size() == 0) begin
        $error("result beat arrived with no execution report outstanding");
        fails++;
        return;
      end
      e = awaited.pop_front();
      check_field("action", e.action, d[1:0]);
      check_field("slot", e.slot, d[4:2]);
      check_field("slot_count", e.slot_count, d[36:5]);
      check_field("calls_total", e.calls_total, d[100:37]);
      check_field("elements_total", e.elements_total, d[164:101]);
      check_field("time_total", e.ns_total, d[228:165]);
      check_field("specialize_advised", e.specialize, d[229]);
      check_field("dominant_valid", e.dom_valid, d[230]);
      check_field("dominant_count_value", e.dom_key, d[262:231]);
      check_field("pad", 64'd0, d[263]);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // elem_count [31:0], exec_time_ns [71:32]
  logic [sft_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // action [1:0], slot [4:2], slot_count [36:5], calls_total [100:37],
  // elements_total [164:101], time_total [228:165], specialize_advised [229],
  // dominant_valid [230], dominant_count_value [262:231], zero [263]
  logic [sft_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  freq_checker_t sb = new();
  logic [31:0] pool [8];
  int unsigned tx_pct = 0;
  int unsigned rx_pct = 0;
  int unsigned results_seen = 0;

  size_frequency_tracker u_top (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_beat(m_tdata);
      results_seen <= results_seen + 1;
    end
  end

  initial begin : result_sink
    int unsigned long_holds;
    long_holds = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_holds < 2 && results_seen >= 300 + 400 * long_holds) begin
        long_holds++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("size_frequency_tracker: mismatch");
    $finish;
  end

  function automatic logic [39:0] next_ns();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return TIME_MAX;
    if (r == 2) return 40'($urandom_range(0, 1000));
    return {8'($urandom_range(0, 255)), 32'($urandom)};
  endfunction

  function automatic logic [31:0] next_key(key_mix_t mix);
    int unsigned r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    k = $urandom;
    case (mix)
      MIX_HOT: if (r < 95) k = pool[2];
      MIX_CHURN: begin
        if (r < 40) k = pool[$urandom_range(0, 7)];
        else if (r < 60) k = pool[2];
      end
      MIX_POOL: if (r < 92) k = pool[$urandom_range(0, 7)];
      default: begin
        if (r < 50) k = pool[$urandom_range(0, 7)];
        else if (r < 75) k = pool[$urandom_range(0, 7)] ^ (32'd1 << $urandom_range(0, 31));
      end
    endcase
    return k;
  endfunction

  task automatic send_call(input logic [31:0] cnt, input logic [39:0] t);
    if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tdata <= {t, cnt};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.record_call(cnt, t);
  endtask

  task automatic program_min_calls(input logic [2:0] addr, input logic [31:0] value);
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == MIN_CALLS_ADDR) sb.min_calls = value;
    paddr <= MIN_CALLS_ADDR;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_field("min_calls", sb.min_calls, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input key_mix_t mix, input int unsigned items,
                           input int unsigned calm_tail);
    int unsigned run_left;
    logic [31:0] key;
    run_left = 0;
    key = '0;
    for (int unsigned k = 0; k < items; k++) begin
      if (items - k <= calm_tail) begin
        tx_pct = 0;
        rx_pct = 0;
      end
      // Pool keys arrive in runs so that a fresh entry can climb past the replace limit.
      if (run_left == 0) begin
        key = next_key(mix);
        run_left = (mix == MIX_POOL) ? $urandom_range(1, 8) :
                   (mix == MIX_NEAR) ? $urandom_range(1, 3) : 1;
      end
      run_left--;
      send_call(key, next_ns());
    end
  endtask

  initial begin : stimulus
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < 8; i++) pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    program_min_calls(SPARE_ADDR, $urandom);

    tx_pct = 20;
    rx_pct = 8;
    send_call(pool[0], '0);
    send_call(pool[0], TIME_MAX);
    send_call(pool[1], TIME_MAX);
    send_call(pool[1], '0);
    for (int i = 2; i < 8; i++) send_call(pool[i], next_ns());
    send_call(32'h8000_0000, 40'h80_0000_0000);
    send_call(32'h0000_0001, 40'd1);
    repeat (4) send_call(pool[0], next_ns());
    send_call(32'h5555_5555, 40'h55_5555_5555);
    send_call(32'hAAAA_AAAA, 40'hAA_AAAA_AAAA);
    send_call(pool[1], next_ns());
    send_call(32'h8000_0000, next_ns());

    program_min_calls(MIN_CALLS_ADDR, '1);
    tx_pct = 20;
    rx_pct = 8;
    run_phase(MIX_HOT, 170, 0);

    program_min_calls(MIN_CALLS_ADDR, '0);
    tx_pct = 0;
    rx_pct = 12;
    run_phase(MIX_CHURN, 250, 0);

    program_min_calls(MIN_CALLS_ADDR, 32'(sb.calls_sum) + 32'd120);
    tx_pct = 40;
    rx_pct = 4;
    run_phase(MIX_POOL, 250, 0);

    program_min_calls(MIN_CALLS_ADDR, 32'(sb.calls_sum) + 32'd150);
    tx_pct = 15;
    rx_pct = 6;
    run_phase(MIX_NEAR, 270, 150);

    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.fails == 0 && sb.awaited.size() == 0)
      $display("size_frequency_tracker: match");
    else
      $display("size_frequency_tracker: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sft_pkg.sv
hdl/sft_table.sv
hdl/size_frequency_tracker.sv
hdl/sft_checker.sv
sim/tb_size_frequency_tracker.sv
